FILE: rtl/dtsc_pkg.sv
// ----------------------------------------------------------------------------
// dtsc_pkg
// Shared types, constants and tables for the date-to-seconds compare block.
// ----------------------------------------------------------------------------
package dtsc_pkg;

   localparam logic [11:0] BASE_YEAR       = 12'd1900;
   localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
   localparam logic [24:0] SECS_PER_YEAR   = 25'd31536000;
   localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
   localparam logic [5:0]  SECS_PER_MINUTE = 6'd60;
   localparam logic [9:0]  MS_PER_SEC      = 10'd1000;
   localparam logic [8:0]  BASE_MOD400     = 9'd300;
   localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;

   localparam int          CSR_IDX_W = 3;
   localparam int          CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_REF_YEAR        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_MONTH       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_DAY         = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_HOUR        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_MINUTE      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_SECOND      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_MILLISECOND = 3'd6;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [9:0]  millisecond;
   } req_type;

   typedef struct packed {
      logic [32:0]        total_seconds;
      logic signed [43:0] diff_ms;
      logic               is_before;
      logic               is_after;
      logic               is_equal;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_IDLE   = 4'd0,
      OP_YEAR   = 4'd1,
      OP_MONTH  = 4'd2,
      OP_DAY    = 4'd3,
      OP_HOUR   = 4'd4,
      OP_MINSEC = 4'd5,
      OP_SCALE  = 4'd6,
      OP_DIFF   = 4'd7,
      OP_EMIT   = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      CND_NONE  = 3'd0,
      CND_NOREQ = 3'd1,
      CND_YEAR  = 3'd2,
      CND_MONTH = 3'd3,
      CND_FULL  = 3'd4
   } cond_type;

   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] PC_LAST = 4'd8;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [PC_W-1:0]     target;
   } uword_type;

   typedef struct packed {
      logic year_busy;
      logic month_busy;
   } lane_status_type;

   typedef struct packed {
      logic req_valid;
      logic year_busy;
      logic month_busy;
      logic out_full;
   } seq_status_type;

   function automatic int sec_width(input int span);
      return $clog2((longint'(span) + 64'd1) * 64'd31622400);
   endfunction

   function automatic int ms_width(input int span);
      return $clog2((longint'(span) + 64'd1) * 64'd31622400 * 64'd1000);
   endfunction

   // seconds in month idx (0 is January)
   function automatic logic [21:0] month_secs(input logic leap, input logic [3:0] idx);
      logic [4:0] days;
      case (idx)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: days = 5'd31;
         4'd3, 4'd5, 4'd8, 4'd10:                  days = 5'd30;
         4'd1:                                     days = leap ? 5'd29 : 5'd28;
         default:                                  days = 5'd0;
      endcase
      return 22'(days) * 22'(SECS_PER_DAY);
   endfunction

endpackage

FILE: rtl/dtsc_chan_if.sv
// ----------------------------------------------------------------------------
// dtsc_chan_if
// Valid/ready channel carrying one request or response payload.
// ----------------------------------------------------------------------------
interface dtsc_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/dtsc_seq.sv
// ----------------------------------------------------------------------------
// dtsc_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module dtsc_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  dtsc_pkg::seq_status_type status,
   output dtsc_pkg::op_type         op,
   output logic                    ready
);

   function automatic dtsc_pkg::uword_type ucode(input logic [dtsc_pkg::PC_W-1:0] pc);
      dtsc_pkg::uword_type w;
      case (pc)
         4'd0:    w = '{dtsc_pkg::OP_IDLE,   dtsc_pkg::CND_NOREQ, 4'd0};
         4'd1:    w = '{dtsc_pkg::OP_YEAR,   dtsc_pkg::CND_YEAR,  4'd1};
         4'd2:    w = '{dtsc_pkg::OP_MONTH,  dtsc_pkg::CND_MONTH, 4'd2};
         4'd3:    w = '{dtsc_pkg::OP_DAY,    dtsc_pkg::CND_NONE,  4'd0};
         4'd4:    w = '{dtsc_pkg::OP_HOUR,   dtsc_pkg::CND_NONE,  4'd0};
         4'd5:    w = '{dtsc_pkg::OP_MINSEC, dtsc_pkg::CND_NONE,  4'd0};
         4'd6:    w = '{dtsc_pkg::OP_SCALE,  dtsc_pkg::CND_NONE,  4'd0};
         4'd7:    w = '{dtsc_pkg::OP_DIFF,   dtsc_pkg::CND_NONE,  4'd0};
         4'd8:    w = '{dtsc_pkg::OP_EMIT,   dtsc_pkg::CND_FULL,  4'd8};
         default: w = '{dtsc_pkg::OP_IDLE,   dtsc_pkg::CND_NONE,  4'd0};
      endcase
      return w;
   endfunction

   logic [dtsc_pkg::PC_W-1:0] pc_ff;
   logic [dtsc_pkg::PC_W-1:0] pc_in;
   dtsc_pkg::uword_type       word;
   logic                      take;

   always_comb begin
      word = ucode(pc_ff);
      case (word.cond)
         dtsc_pkg::CND_NOREQ: take = !status.req_valid;
         dtsc_pkg::CND_YEAR:  take = status.year_busy;
         dtsc_pkg::CND_MONTH: take = status.month_busy;
         dtsc_pkg::CND_FULL:  take = status.out_full;
         default:             take = 1'b0;
      endcase
      if (take) begin
         pc_in = word.target;
      end else if (pc_ff >= dtsc_pkg::PC_LAST) begin
         pc_in = '0;
      end else begin
         pc_in = pc_ff + dtsc_pkg::PC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign op    = word.op;
   assign ready = (word.op == dtsc_pkg::OP_IDLE);

endmodule

FILE: rtl/dtsc_lane.sv
// ----------------------------------------------------------------------------
// dtsc_lane
// Datapath lane: accumulates seconds of one date under sequencer control.
// ----------------------------------------------------------------------------
module dtsc_lane #(
   parameter  int YEAR_SPAN = 256,
   localparam int SEC_W = dtsc_pkg::sec_width(YEAR_SPAN),
   localparam int MS_W  = dtsc_pkg::ms_width(YEAR_SPAN)
) (
   input  logic                      clock,
   input  dtsc_pkg::op_type          op,
   input  logic                      load,
   input  dtsc_pkg::req_type         date,
   output logic [SEC_W-1:0]          sec,
   output logic [MS_W-1:0]           ms_total,
   output dtsc_pkg::lane_status_type status
);

   localparam int OFF_W = (YEAR_SPAN > 1) ? $clog2(YEAR_SPAN) : 1;

   logic [OFF_W-1:0] ytgt_ff, ytgt_in, ycnt_ff, ycnt_in;
   logic [1:0]       c4_ff, c4_in;
   logic [6:0]       c100_ff, c100_in;
   logic [8:0]       c400_ff, c400_in;
   logic [3:0]       mtgt_ff, mtgt_in, mcnt_ff, mcnt_in;
   logic [4:0]       day_ff, day_in, hour_ff, hour_in;
   logic [5:0]       minute_ff, minute_in, second_ff, second_in;
   logic [9:0]       milli_ff, milli_in;
   logic [SEC_W-1:0] acc_ff, acc_in;
   logic [MS_W-1:0]  ms_ff, ms_in;
   logic             leap;
   logic [11:0]      yoff;

   assign leap = ((c4_ff == 2'd0) && (c100_ff != 7'd0)) || (c400_ff == 9'd0);
   assign yoff = date.year - dtsc_pkg::BASE_YEAR;
   assign status.year_busy  = (ycnt_ff != ytgt_ff);
   assign status.month_busy = (mcnt_ff != mtgt_ff);

   always_comb begin
      ytgt_in   = ytgt_ff;
      ycnt_in   = ycnt_ff;
      c4_in     = c4_ff;
      c100_in   = c100_ff;
      c400_in   = c400_ff;
      mtgt_in   = mtgt_ff;
      mcnt_in   = mcnt_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      milli_in  = milli_ff;
      acc_in    = acc_ff;
      ms_in     = ms_ff;
      if (load) begin
         if (date.year < dtsc_pkg::BASE_YEAR) begin
            ytgt_in = '0;
         end else if (yoff > 12'(YEAR_SPAN - 1)) begin
            ytgt_in = OFF_W'(YEAR_SPAN - 1);
         end else begin
            ytgt_in = OFF_W'(yoff);
         end
         if (date.month == 4'd0) begin
            mtgt_in = 4'd0;
         end else if (date.month > 4'd13) begin
            mtgt_in = dtsc_pkg::MONTHS_PER_YEAR;
         end else begin
            mtgt_in = date.month - 4'd1;
         end
         day_in    = (date.day == 5'd0) ? 5'd0 : date.day - 5'd1;
         hour_in   = date.hour;
         minute_in = date.minute;
         second_in = date.second;
         milli_in  = date.millisecond;
         ycnt_in   = '0;
         mcnt_in   = '0;
         c4_in     = 2'd0;
         c100_in   = 7'd0;
         c400_in   = dtsc_pkg::BASE_MOD400;
         acc_in    = '0;
      end else begin
         case (op)
            dtsc_pkg::OP_YEAR: begin
               if (status.year_busy) begin
                  acc_in  = acc_ff + SEC_W'(dtsc_pkg::SECS_PER_YEAR)
                          + (leap ? SEC_W'(dtsc_pkg::SECS_PER_DAY) : '0);
                  ycnt_in = ycnt_ff + OFF_W'(1);
                  c4_in   = c4_ff + 2'd1;
                  c100_in = (c100_ff == 7'd99) ? 7'd0 : c100_ff + 7'd1;
                  c400_in = (c400_ff == 9'd399) ? 9'd0 : c400_ff + 9'd1;
               end
            end
            dtsc_pkg::OP_MONTH: begin
               if (status.month_busy) begin
                  acc_in  = acc_ff + SEC_W'(dtsc_pkg::month_secs(leap, mcnt_ff));
                  mcnt_in = mcnt_ff + 4'd1;
               end
            end
            dtsc_pkg::OP_DAY: begin
               acc_in = acc_ff + SEC_W'({5'd0, day_ff} * {5'd0, dtsc_pkg::SECS_PER_DAY});
            end
            dtsc_pkg::OP_HOUR: begin
               acc_in = acc_ff + SEC_W'({12'd0, hour_ff} * {5'd0, dtsc_pkg::SECS_PER_HOUR});
            end
            dtsc_pkg::OP_MINSEC: begin
               acc_in = acc_ff + SEC_W'({6'd0, minute_ff} * {6'd0, dtsc_pkg::SECS_PER_MINUTE})
                      + SEC_W'(second_ff);
            end
            dtsc_pkg::OP_SCALE: begin
               ms_in = MS_W'({10'd0, acc_ff} * {{SEC_W{1'b0}}, dtsc_pkg::MS_PER_SEC})
                     + MS_W'(milli_ff);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      ytgt_ff   <= ytgt_in;
      ycnt_ff   <= ycnt_in;
      c4_ff     <= c4_in;
      c100_ff   <= c100_in;
      c400_ff   <= c400_in;
      mtgt_ff   <= mtgt_in;
      mcnt_ff   <= mcnt_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      milli_ff  <= milli_in;
      acc_ff    <= acc_in;
      ms_ff     <= ms_in;
   end

   assign sec      = acc_ff;
   assign ms_total = ms_ff;

endmodule

FILE: rtl/datetime_to_seconds_compare_top.sv
// A request is accepted only while the sequencer is idle. The year loop runs over the
// larger clamped year offset (years past 1900), the month loop over the larger
// completed-month count of the request and reference dates, then the day, hour,
// minsec, scale, diff and emit steps; emit waits while the last response is unaccepted.
// Reset: synchronous, active high; clears sequencer and response valid, and
// returns the reference date to 1900-01-01 00:00:00.000.
// ----------------------------------------------------------------------------
// datetime_to_seconds_compare_top
// Converts a calendar date to seconds since 1900 and compares it in
// milliseconds with a reference date held in CSRs.
// ----------------------------------------------------------------------------
module datetime_to_seconds_compare_top #(
   parameter int YEAR_SPAN = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   dtsc_chan_if.sink                            req_chan,
   dtsc_chan_if.source                          rsp_chan,
   input  logic                                 csr_we,
   input  logic [dtsc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dtsc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int SEC_W = dtsc_pkg::sec_width(YEAR_SPAN);
   localparam int MS_W  = dtsc_pkg::ms_width(YEAR_SPAN);
   localparam int DW    = (MS_W + 1 > 44) ? MS_W + 1 : 44;
   localparam int TW    = (SEC_W > 33) ? SEC_W : 33;

   dtsc_pkg::req_type         ref_ff, ref_in;
   dtsc_pkg::op_type          op;
   dtsc_pkg::seq_status_type  seq_status;
   dtsc_pkg::lane_status_type in_status, ref_status;
   logic                      seq_ready;
   logic                      fire;
   logic [SEC_W-1:0]          in_sec, ref_sec;
   logic [MS_W-1:0]           in_ms, ref_ms;
   logic [DW-1:0]             diff_wide;
   logic [TW-1:0]             sec_wide;
   logic [43:0]               diff_ff, diff_in;
   logic                      before_ff, before_in, after_ff, after_in;
   logic                      equal_ff, equal_in;
   dtsc_pkg::rsp_type         rsp_data_ff, rsp_data_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      emit;

   assign fire           = req_chan.valid && seq_ready;
   assign req_chan.ready = seq_ready;

   assign seq_status.req_valid  = req_chan.valid;
   assign seq_status.year_busy  = in_status.year_busy || ref_status.year_busy;
   assign seq_status.month_busy = in_status.month_busy || ref_status.month_busy;
   assign seq_status.out_full   = rsp_valid_ff && !rsp_chan.ready;

   dtsc_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (seq_status),
      .op     (op),
      .ready  (seq_ready)
   );

   dtsc_lane #(.YEAR_SPAN(YEAR_SPAN)) u_in_lane (
      .clock    (clock),
      .op       (op),
      .load     (fire),
      .date     (req_chan.data),
      .sec      (in_sec),
      .ms_total (in_ms),
      .status   (in_status)
   );

   dtsc_lane #(.YEAR_SPAN(YEAR_SPAN)) u_ref_lane (
      .clock    (clock),
      .op       (op),
      .load     (fire),
      .date     (ref_ff),
      .sec      (ref_sec),
      .ms_total (ref_ms),
      .status   (ref_status)
   );

   // reference CSRs
   always_comb begin
      ref_in = ref_ff;
      if (csr_we) begin
         case (csr_index)
            dtsc_pkg::CSR_REF_YEAR:        ref_in.year        = csr_wdata;
            dtsc_pkg::CSR_REF_MONTH:       ref_in.month       = csr_wdata[3:0];
            dtsc_pkg::CSR_REF_DAY:         ref_in.day         = csr_wdata[4:0];
            dtsc_pkg::CSR_REF_HOUR:        ref_in.hour        = csr_wdata[4:0];
            dtsc_pkg::CSR_REF_MINUTE:      ref_in.minute      = csr_wdata[5:0];
            dtsc_pkg::CSR_REF_SECOND:      ref_in.second      = csr_wdata[5:0];
            dtsc_pkg::CSR_REF_MILLISECOND: ref_in.millisecond = csr_wdata[9:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ff <= '{dtsc_pkg::BASE_YEAR, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0};
      end else begin
         ref_ff <= ref_in;
      end
   end

   // compare
   assign diff_wide = DW'(in_ms) - DW'(ref_ms);
   assign sec_wide  = TW'(in_sec);

   always_comb begin
      diff_in   = diff_ff;
      before_in = before_ff;
      after_in  = after_ff;
      equal_in  = equal_ff;
      if (op == dtsc_pkg::OP_DIFF) begin
         diff_in   = diff_wide[43:0];
         before_in = (in_ms < ref_ms);
         after_in  = (in_ms > ref_ms);
         equal_in  = (in_ms == ref_ms);
      end
   end

   always_ff @(posedge clock) begin
      diff_ff   <= diff_in;
      before_ff <= before_in;
      after_ff  <= after_in;
      equal_ff  <= equal_in;
   end

   // response register
   assign emit = (op == dtsc_pkg::OP_EMIT) && !seq_status.out_full;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_data_in.total_seconds = sec_wide[32:0];
         rsp_data_in.diff_ms       = diff_ff;
         rsp_data_in.is_before     = before_ff;
         rsp_data_in.is_after      = after_ff;
         rsp_data_in.is_equal      = equal_ff;
         rsp_valid_in              = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(op == dtsc_pkg::OP_EMIT))
      else $error("response valid rose outside the emit step");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      fire |=> !req_chan.ready)
      else $error("sequencer stayed idle after accepting a request");

   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> $onehot({rsp_chan.data.is_before, rsp_chan.data.is_after,
                                  rsp_chan.data.is_equal}))
      else $error("compare flags not one-hot");
`endif

endmodule
